/* rtl/core/lpdr_pkg.sv */
// Shared widths, defaults and the result record of the label pair renumbering block.
package lpdr_pkg;

  // Field widths of the channels
  localparam int unsigned LABEL_W = 10;
  localparam int unsigned KEY_W   = 2 * LABEL_W;
  localparam int unsigned DENSE_W = 10;
  localparam int unsigned COUNT_W = 11;

  // Default store size (distinct pairs per run)
  localparam int unsigned MAX_NODES_DEF = 1024;

  // Result buffer depth; a power of two so the pointers wrap on their own
  localparam int unsigned FIFO_DEPTH = 4;

  // One result item as it travels from the match stage to the output buffer
  typedef struct packed {
    logic [DENSE_W-1:0] dense_id;
    logic               newly_added;
    logic [COUNT_W-1:0] distinct_count;
    logic               overflow;
  } lpdr_result_t;

endpackage

/* rtl/core/label_pair_dense_renumber_top.sv */
// Top level of the label pair dense renumbering block.
// Each input transfer carries one node's label pair; the block answers with the pair's
// dense id (first-seen order since the last clear), whether it was just added, the
// running distinct count and an overflow flag (new pair, store full). One item is
// taken per cycle while the result buffer has credit; a result passes the map memory
// read, the key memory read and the resolve into the result buffer, in that order, and
// up to four items may be outstanding in the result buffer, which sets full rate as long
// as the output side takes one result per cycle. After reset the key-to-id map memory
// is swept clear, one entry per cycle, over all 1,048,576 entries; input ready stays
// low until the sweep ends. start_of_run clears the store via the count, not a sweep.
module label_pair_dense_renumber_top import lpdr_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LABEL_W-1:0] first_label_i,
  input  logic [LABEL_W-1:0] second_label_i,
  input  logic               start_of_run_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DENSE_W-1:0] dense_id_o,
  output logic               newly_added_o,
  output logic [COUNT_W-1:0] distinct_count_o,
  output logic               overflow_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);

  logic             acc;
  logic [KEY_W-1:0] key;
  logic             clr_done, has_credit;
  logic [IDX_W-1:0] map_id;
  logic [KEY_W-1:0] keys_rd;
  logic             wr_en;
  logic [KEY_W-1:0] wr_key;
  logic [IDX_W-1:0] wr_id;
  logic             res_vld;
  lpdr_result_t     res, out_res;

  // Input transfer
  assign in_ready_o = clr_done && has_credit;
  assign acc        = in_valid_i && in_ready_o;
  assign key        = {first_label_i, second_label_i};

  lpdr_store #(.MAX_NODES(MAX_NODES)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_key_i   (key),
    .wr_en_i    (wr_en),
    .wr_key_i   (wr_key),
    .wr_id_i    (wr_id),
    .map_id_o   (map_id),
    .keys_rd_o  (keys_rd),
    .clr_done_o (clr_done)
  );

  lpdr_match #(.MAX_NODES(MAX_NODES)) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .key_i     (key),
    .start_i   (start_of_run_i),
    .map_id_i  (map_id),
    .keys_rd_i (keys_rd),
    .wr_en_o   (wr_en),
    .wr_key_o  (wr_key),
    .wr_id_o   (wr_id),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  lpdr_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .credit_take_i (acc),
    .push_i        (res_vld),
    .push_data_i   (res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_res),
    .has_credit_o  (has_credit)
  );

  // Output fields
  assign dense_id_o       = out_res.dense_id;
  assign newly_added_o    = out_res.newly_added;
  assign distinct_count_o = out_res.distinct_count;
  assign overflow_o       = out_res.overflow;

endmodule

/* rtl/core/lpdr_store.sv */
// Pair store: key-to-id map memory with its power-up clear, and the id-to-key memory.
module lpdr_store import lpdr_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [KEY_W-1:0]             rd_key_i,
  input  logic                         wr_en_i,
  input  logic [KEY_W-1:0]             wr_key_i,
  input  logic [$clog2(MAX_NODES)-1:0] wr_id_i,
  output logic [$clog2(MAX_NODES)-1:0] map_id_o,
  output logic [KEY_W-1:0]             keys_rd_o,
  output logic                         clr_done_o
);

  localparam int unsigned IDX_W     = $clog2(MAX_NODES);
  localparam int unsigned MAP_DEPTH = 2 ** KEY_W;

  logic [IDX_W-1:0] map_mem  [MAP_DEPTH];
  logic [KEY_W-1:0] keys_mem [MAX_NODES];

  logic             clr_busy_q;
  logic [KEY_W-1:0] clr_idx_q;
  logic [IDX_W-1:0] map_id_q;
  logic [KEY_W-1:0] keys_rd_q;

  // Power-up sweep: one map entry per cycle is zeroed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + KEY_W'(1);
      if (&clr_idx_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Map memory: sweep write or insert write, read on input transfer
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      map_mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      map_mem[wr_key_i] <= wr_id_i;
    end
    if (rd_en_i) begin
      map_id_q <= map_mem[rd_key_i];
    end
  end

  // Key memory: slot written on insert, read at the id the map returned
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      keys_mem[wr_id_i] <= wr_key_i;
    end
    keys_rd_q <= keys_mem[map_id_q];
  end

  assign map_id_o   = map_id_q;
  assign keys_rd_o  = keys_rd_q;
  assign clr_done_o = !clr_busy_q;

endmodule

/* rtl/core/lpdr_match.sv */
// Match pipeline: stage registers, recent-write bypass, pair count and result build.
module lpdr_match import lpdr_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [KEY_W-1:0]             key_i,
  input  logic                         start_i,
  input  logic [$clog2(MAX_NODES)-1:0] map_id_i,
  input  logic [KEY_W-1:0]             keys_rd_i,
  output logic                         wr_en_o,
  output logic [KEY_W-1:0]             wr_key_o,
  output logic [$clog2(MAX_NODES)-1:0] wr_id_o,
  output logic                         res_vld_o,
  output lpdr_result_t                 res_o
);

  localparam int unsigned IDX_W    = $clog2(MAX_NODES);
  localparam int unsigned CNT_W    = $clog2(MAX_NODES + 1);
  localparam int unsigned IdExtW   = (IDX_W > DENSE_W) ? IDX_W : DENSE_W;
  localparam int unsigned CntExtW  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Stage 1: map lookup data arrives
  logic             s1_vld_q;
  logic [KEY_W-1:0] s1_key_q;
  logic             s1_start_q;
  // Stage 2: key lookup data arrives, item resolves
  logic             s2_vld_q;
  logic [KEY_W-1:0] s2_key_q;
  logic             s2_start_q;
  logic [IDX_W-1:0] s2_map_q;

  // Inserts made at the last edge (wr1) and the one before (wr2)
  logic             wr1_vld_q, wr2_vld_q;
  logic [KEY_W-1:0] wr1_key_q, wr2_key_q;
  logic [IDX_W-1:0] wr1_id_q,  wr2_id_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [CNT_W-1:0]   cnt_eff;
  logic               fwd1_hit, fwd2_hit, mem_hit, hit, full, ins;
  logic [IDX_W-1:0]   hit_id, id_out;
  logic [IdExtW-1:0]  id_ext;
  logic [CntExtW-1:0] cnt_ext;

  // Pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      wr1_vld_q <= 1'b0;
      wr2_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      s1_vld_q  <= acc_i;
      s2_vld_q  <= s1_vld_q;
      wr1_vld_q <= wr_en_o;
      wr2_vld_q <= wr1_vld_q;
      if (s2_vld_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_key_q   <= key_i;
    s1_start_q <= start_i;
    s2_key_q   <= s1_key_q;
    s2_start_q <= s1_start_q;
    s2_map_q   <= map_id_i;
    wr1_key_q  <= wr_key_o;
    wr1_id_q   <= wr_id_o;
    wr2_key_q  <= wr1_key_q;
    wr2_id_q   <= wr1_id_q;
  end

  // Resolve: a slot counts only below the live count; the newest insert wins,
  // and a slot rewritten by a newer insert no longer holds the older key
  always_comb begin
    cnt_eff  = s2_start_q ? '0 : cnt_q;
    fwd1_hit = wr1_vld_q && (wr1_key_q == s2_key_q) && (CNT_W'(wr1_id_q) < cnt_eff);
    fwd2_hit = wr2_vld_q && (wr2_key_q == s2_key_q) && (CNT_W'(wr2_id_q) < cnt_eff)
               && !(wr1_vld_q && (wr1_id_q == wr2_id_q));
    mem_hit  = (CNT_W'(s2_map_q) < cnt_eff) && (keys_rd_i == s2_key_q)
               && !(wr1_vld_q && (wr1_id_q == s2_map_q));
    hit      = fwd1_hit || fwd2_hit || mem_hit;
    priority if (fwd1_hit) begin
      hit_id = wr1_id_q;
    end else if (fwd2_hit) begin
      hit_id = wr2_id_q;
    end else begin
      hit_id = s2_map_q;
    end
    full   = (cnt_eff == CNT_W'(MAX_NODES));
    ins    = !hit && !full;
    if (hit) begin
      id_out = hit_id;
    end else if (ins) begin
      id_out = cnt_eff[IDX_W-1:0];
    end else begin
      id_out = '0;
    end
    cnt_d   = ins ? (cnt_eff + CNT_W'(1)) : cnt_eff;
    id_ext  = IdExtW'(id_out);
    cnt_ext = CntExtW'(cnt_d);
  end

  // Insert write and result record
  assign wr_en_o  = s2_vld_q && ins;
  assign wr_key_o = s2_key_q;
  assign wr_id_o  = id_out;

  assign res_vld_o            = s2_vld_q;
  assign res_o.dense_id       = id_ext[DENSE_W-1:0];
  assign res_o.newly_added    = ins;
  assign res_o.distinct_count = cnt_ext[COUNT_W-1:0];
  assign res_o.overflow       = !hit && full;

`ifndef ASSERT_OFF
  // Count stays within the store size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_NODES))
    else $error("pair count above store size");

  // When the count grows, it grows by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("pair count jumped");

  // A clearing item always becomes the only stored pair
  a_clear_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_start_q) |=> (cnt_q == CNT_W'(1)))
    else $error("clear did not leave exactly one pair");
`endif

endmodule

/* rtl/core/lpdr_out_fifo.sv */
// Result buffer with credit tracking so the match pipeline never stalls.
module lpdr_out_fifo import lpdr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         credit_take_i,
  input  logic         push_i,
  input  lpdr_result_t push_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lpdr_result_t out_data_o,
  output logic         has_credit_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 1);

  lpdr_result_t     buf_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [OCC_W-1:0] stored_q, occ_q;
  logic             pop;

  assign pop = out_valid_o && out_ready_i;

  // Pointers, stored count and outstanding items (taken but not delivered)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      stored_q <= '0;
      occ_q    <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      stored_q <= stored_q + OCC_W'(push_i) - OCC_W'(pop);
      occ_q    <= occ_q + OCC_W'(credit_take_i) - OCC_W'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= push_data_i;
    end
  end

  assign out_valid_o  = (stored_q != '0);
  assign out_data_o   = buf_q[rptr_q];
  assign has_credit_o = (occ_q < OCC_W'(FIFO_DEPTH));

`ifndef ASSERT_OFF
  // Buffered results never outnumber outstanding items
  a_stored_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= occ_q)
    else $error("more buffered results than outstanding items");

  // Credits guarantee room for every push
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (stored_q != OCC_W'(FIFO_DEPTH)))
    else $error("push into full result buffer");
`endif

endmodule
